// File: src/pfd_pkg.sv
`default_nettype none

package pfd_pkg;

  // Frame layout
  localparam int unsigned FRAME_LENGTH = 28;
  localparam int unsigned IDX_W        = $clog2(FRAME_LENGTH);
  localparam int unsigned OFS_HEADING  = 2;
  localparam int unsigned OFS_X        = 14;
  localparam int unsigned OFS_Y        = 18;
  localparam int unsigned OFS_TAIL0    = 26;
  localparam int unsigned OFS_TAIL1    = 27;

  // Field widths
  localparam int unsigned XY_W    = 22;
  localparam int unsigned HEAD_W  = 20;
  localparam int unsigned AGE_W   = 10;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // Range limits as IEEE single magnitudes: 20000.0 and 360.0
  localparam logic [30:0] LIM_XY_BITS  = 31'h469C4000;
  localparam logic [30:0] LIM_ANG_BITS = 31'h43B40000;

  // round(pi * 2^29)
  localparam logic [30:0] PI_Q29 = 31'h6487ED51;

  // Exponent offsets: X/Y shift is e-134, heading shift is e-163
  localparam logic [7:0] XY_EXP_BIAS   = 8'd134;
  localparam logic [7:0] XY_EXP_MAXSH  = 8'd141;
  localparam logic [7:0] HEAD_EXP_BIAS = 8'd163;

  // Exact reciprocal of 125 for 28-bit dividends: q = (n * M) >> 35
  localparam int unsigned      XY_N_W    = 28;
  localparam logic [28:0]      RECIP_125 = 29'd274877907;
  localparam int unsigned      RECIP_125_SH = 35;
  // Exact reciprocal of 45 for 25-bit dividends: q = (n * M) >> 31
  localparam int unsigned      HD_N_W    = 25;
  localparam logic [25:0]      RECIP_45  = 26'd47721859;
  localparam int unsigned      RECIP_45_SH = 31;

  localparam int unsigned HPROD_W = 55;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST  = 3'd0,
    REG_HEADER_SECOND = 3'd1,
    REG_TAIL_FIRST    = 3'd2,
    REG_TAIL_SECOND   = 3'd3,
    REG_STALE_LIMIT   = 3'd4
  } cfg_reg_e;

  // Input opcodes
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // Middle pipeline stage: frame status plus the partly scaled values
  typedef struct packed {
    logic               complete;
    logic               accepted;
    logic               fresh;
    logic               x_sign;
    logic [XY_N_W-1:0]  x_n;
    logic               y_sign;
    logic [XY_N_W-1:0]  y_n;
    logic               h_sign;
    logic [HPROD_W-1:0] h_prod;
    logic [5:0]         h_shift;
  } mid_t;

endpackage

`default_nettype wire

// File: src/position_frame_deframer.sv
`default_nettype none

// Position sensor deframer. Each input transfer is either a received serial byte
// (tuser = 0) or a one-millisecond tick (tuser = 1); each one produces exactly one
// result transfer. The block hunts for the two-byte header, collects a 28-byte
// frame, checks the tail and decodes heading (degrees, byte 2) and X/Y (mm, bytes
// 14 and 18) from little-endian IEEE singles; NaN, infinity and out-of-range values
// reject the frame. Good frames update X/Y (meters) and heading (radians), all
// signed Q16, and restart the age counter; position_fresh reports age below
// stale_limit. Throughput is one item per clock unless the output stalls; stages are
// input register, frame logic plus first scaling step, reciprocal multiply into the
// output register. Back-pressure on the master side stalls the whole pipeline.
module position_frame_deframer
  import pfd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  wire logic                 s_axis_tuser,   // [0] opcode
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [0] frame_complete, [1] frame_accepted, [23:2] pos_x, [45:24] pos_y,
  // [65:46] heading, [66] position_fresh, [71:67] zero
  output logic [71:0]               m_axis_tdata
);

  // ---------------------------------------------------------------------------
  // Scaling helpers
  // ---------------------------------------------------------------------------

  // floor(v * 65536) / 8 after adding 0.5 ulp of the /1000 step, v from float bits
  function automatic logic [XY_N_W-1:0] xy_prescale(input logic [31:0] bits);
    logic [7:0]  ex;
    logic [7:0]  eff;
    logic [23:0] mant;
    logic [2:0]  lsh;
    logic [7:0]  rsh_raw;
    logic [4:0]  rsh;
    logic [30:0] n;
    logic [31:0] sum;
    ex   = bits[30:23];
    eff  = (ex == 8'd0) ? 8'd1 : ex;
    mant = {(ex != 8'd0), bits[22:0]};
    lsh  = 3'd0;
    rsh  = 5'd0;
    rsh_raw = 8'd0;
    if (eff >= XY_EXP_BIAS) begin
      lsh = (eff >= XY_EXP_MAXSH) ? 3'd7 : 3'(eff - XY_EXP_BIAS);
      n   = 31'(mant) << lsh;
    end else begin
      rsh_raw = XY_EXP_BIAS - eff;
      rsh     = (rsh_raw > 8'd31) ? 5'd31 : rsh_raw[4:0];
      n       = 31'(mant) >> rsh;
    end
    sum = 32'(n) + 32'd500;
    return sum[30:3];
  endfunction

  // right shift applied to mant * PI_Q29 for the heading, saturated
  function automatic logic [5:0] head_shift(input logic [7:0] ex);
    logic [7:0] eff;
    logic [7:0] k;
    eff = (ex == 8'd0) ? 8'd1 : ex;
    k   = (eff >= HEAD_EXP_BIAS) ? 8'd0 : (HEAD_EXP_BIAS - eff);
    return (k > 8'd63) ? 6'd63 : k[5:0];
  endfunction

  // finite and magnitude within limit
  function automatic logic in_range(input logic [31:0] bits, input logic [30:0] lim);
    return (bits[30:23] != 8'hFF) && (bits[30:0] <= lim);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]       hdr0_q, hdr1_q, tail0_q, tail1_q;
  logic [AGE_W-1:0] stale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_q  <= 8'd13;
      hdr1_q  <= 8'd10;
      tail0_q <= 8'd10;
      tail1_q <= 8'd13;
      stale_q <= 10'd500;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HEADER_FIRST:  hdr0_q  <= cfg_wdata_i[7:0];
        REG_HEADER_SECOND: hdr1_q  <= cfg_wdata_i[7:0];
        REG_TAIL_FIRST:    tail0_q <= cfg_wdata_i[7:0];
        REG_TAIL_SECOND:   tail1_q <= cfg_wdata_i[7:0];
        REG_STALE_LIMIT:   stale_q <= cfg_wdata_i[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage moves when the output is free or taken
  // ---------------------------------------------------------------------------
  logic adv;
  logic in_vld_q, mid_vld_q, out_vld_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q  <= s_axis_tvalid;
      mid_vld_q <= in_vld_q;
      out_vld_q <= mid_vld_q;
    end
  end

  // Input register
  logic       in_op_q;
  logic [7:0] in_byte_q;

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame sync, checks and age tracking
  // ---------------------------------------------------------------------------
  logic [7:0]       frame_q [FRAME_LENGTH];
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             hdr_seen_q, hdr_seen_d;
  logic             have_pos_q, have_pos_d;
  logic [AGE_W-1:0] age_q, age_d;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic             complete, accepted;
  logic [31:0]      f_head, f_x, f_y;
  logic             step;

  assign step   = adv && in_vld_q;
  assign f_head = {frame_q[OFS_HEADING+3], frame_q[OFS_HEADING+2],
                   frame_q[OFS_HEADING+1], frame_q[OFS_HEADING]};
  assign f_x    = {frame_q[OFS_X+3], frame_q[OFS_X+2], frame_q[OFS_X+1], frame_q[OFS_X]};
  assign f_y    = {frame_q[OFS_Y+3], frame_q[OFS_Y+2], frame_q[OFS_Y+1], frame_q[OFS_Y]};

  always_comb begin
    idx_d      = idx_q;
    hdr_seen_d = hdr_seen_q;
    have_pos_d = have_pos_q;
    age_d      = age_q;
    wr_en      = 1'b0;
    wr_idx     = '0;
    complete   = 1'b0;
    accepted   = 1'b0;
    if (in_op_q == OP_TICK) begin
      if (age_q != AGE_MAX) age_d = age_q + 1'b1;
    end else if (!hdr_seen_q || (idx_q == IDX_W'(1) && in_byte_q != hdr1_q)) begin
      // hunting, or bad second byte: this byte may start a new header
      hdr_seen_d = 1'b0;
      idx_d      = '0;
      if (in_byte_q == hdr0_q) begin
        wr_en      = 1'b1;
        idx_d      = IDX_W'(1);
        hdr_seen_d = 1'b1;
      end
    end else begin
      wr_en  = 1'b1;
      wr_idx = idx_q;
      idx_d  = idx_q + 1'b1;
      if (idx_q == IDX_W'(FRAME_LENGTH - 1)) begin
        // last byte arrives now and is checked straight from the input
        complete   = 1'b1;
        idx_d      = '0;
        hdr_seen_d = 1'b0;
        accepted   = (frame_q[0] == hdr0_q) && (frame_q[1] == hdr1_q) &&
                     (frame_q[OFS_TAIL0] == tail0_q) && (in_byte_q == tail1_q) &&
                     in_range(f_x, LIM_XY_BITS) && in_range(f_y, LIM_XY_BITS) &&
                     in_range(f_head, LIM_ANG_BITS);
        if (accepted) begin
          have_pos_d = 1'b1;
          age_d      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      hdr_seen_q <= 1'b0;
      have_pos_q <= 1'b0;
      age_q      <= '0;
    end else if (step) begin
      idx_q      <= idx_d;
      hdr_seen_q <= hdr_seen_d;
      have_pos_q <= have_pos_d;
      age_q      <= age_d;
    end
  end

  // Frame store, no reset: entries are read only after the frame has filled them
  always_ff @(posedge clk_i) begin
    if (step && wr_en) frame_q[wr_idx] <= in_byte_q;
  end

  // ---------------------------------------------------------------------------
  // Middle stage: pre-scaled X/Y and heading product
  // ---------------------------------------------------------------------------
  mid_t mid_d, mid_q;

  always_comb begin
    mid_d.complete = complete;
    mid_d.accepted = accepted;
    mid_d.fresh    = have_pos_d && (age_d < stale_q);
    mid_d.x_sign   = f_x[31];
    mid_d.x_n      = xy_prescale(f_x);
    mid_d.y_sign   = f_y[31];
    mid_d.y_n      = xy_prescale(f_y);
    mid_d.h_sign   = f_head[31];
    mid_d.h_prod   = HPROD_W'({(f_head[30:23] != 8'd0), f_head[22:0]}) * HPROD_W'(PI_Q29);
    mid_d.h_shift  = head_shift(f_head[30:23]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) mid_q <= mid_d;
  end

  // ---------------------------------------------------------------------------
  // Output stage: divide by 1000 and 180 through reciprocals, sign, store
  // ---------------------------------------------------------------------------
  logic [XY_N_W+28:0]  x_mul, y_mul;
  logic [XY_W-1:0]     x_mag, y_mag, x_fix, y_fix;
  logic [HPROD_W-1:0]  h_shifted;
  logic [27:0]         h_sum;
  logic [HD_N_W+25:0]  h_mul;
  logic [HEAD_W-1:0]   h_mag, h_fix;

  always_comb begin
    x_mul     = (XY_N_W+29)'(mid_q.x_n) * (XY_N_W+29)'(RECIP_125);
    y_mul     = (XY_N_W+29)'(mid_q.y_n) * (XY_N_W+29)'(RECIP_125);
    x_mag     = x_mul[RECIP_125_SH +: XY_W];
    y_mag     = y_mul[RECIP_125_SH +: XY_W];
    x_fix     = mid_q.x_sign ? (XY_W'(0) - x_mag) : x_mag;
    y_fix     = mid_q.y_sign ? (XY_W'(0) - y_mag) : y_mag;
    h_shifted = mid_q.h_prod >> mid_q.h_shift;
    h_sum     = h_shifted[27:0] + 28'd90;
    h_mul     = (HD_N_W+26)'(h_sum[26:2]) * (HD_N_W+26)'(RECIP_45);
    h_mag     = h_mul[RECIP_45_SH +: HEAD_W];
    h_fix     = mid_q.h_sign ? (HEAD_W'(0) - h_mag) : h_mag;
  end

  logic [XY_W-1:0]   pos_x_q, pos_y_q;
  logic [HEAD_W-1:0] heading_q;
  logic              out_complete_q, out_accepted_q, out_fresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      heading_q <= '0;
    end else if (adv && mid_vld_q && mid_q.accepted) begin
      pos_x_q   <= x_fix;
      pos_y_q   <= y_fix;
      heading_q <= h_fix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_complete_q <= mid_q.complete;
      out_accepted_q <= mid_q.accepted;
      out_fresh_q    <= mid_q.fresh;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_fresh_q, heading_q, pos_y_q, pos_x_q,
                          out_accepted_q, out_complete_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idle_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hdr_seen_q |-> idx_q == '0)
    else $error("byte index not zero while hunting for header");

  a_sync_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_seen_q |-> (idx_q != '0) && (idx_q < IDX_W'(FRAME_LENGTH)))
    else $error("byte index out of frame while synchronized");

  a_accept_clears_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && accepted |=> (age_q == '0) && have_pos_q && !hdr_seen_q)
    else $error("accepted frame did not restart age");

  a_accept_needs_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("frame accepted without frame complete");

endmodule

`default_nettype wire

// File: tb/sv/position_frame_deframer_tb.sv
module position_frame_deframer_tb;
  import pfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Deliberate frame defects
  typedef enum int {
    FLAW_NONE,
    FLAW_TAIL_FIRST,
    FLAW_TAIL_SECOND,
    FLAW_HEADER_SECOND
  } frame_flaw_e;

  // One result transfer, unpacked
  typedef struct packed {
    logic              complete;
    logic              accepted;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
    logic [HEAD_W-1:0] hdg;
    logic              fresh;
  } pos_status_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;   // [7:0] data_byte
  logic                 s_axis_tuser = 1'b0; // [0] opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [0] frame_complete, [1] frame_accepted, [23:2] pos_x, [45:24] pos_y,
  // [65:46] heading, [66] position_fresh
  logic [71:0]          m_axis_tdata;

  position_frame_deframer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Traffic shaping knobs
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned tick_mix_pct   = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_left      = 0;
  int unsigned items_sent     = 0;
  int unsigned mismatch_count = 0;

  // Decoder state as the block should hold it
  logic [7:0]        cfg_hdr1  = 8'd13;
  logic [7:0]        cfg_hdr2  = 8'd10;
  logic [7:0]        cfg_tail1 = 8'd10;
  logic [7:0]        cfg_tail2 = 8'd13;
  logic [AGE_W-1:0]  cfg_stale = 10'd500;
  logic [7:0]        shadow_frame [FRAME_LENGTH] = '{default: 8'h00};
  int unsigned       fill_idx  = 0;
  logic              in_sync   = 1'b0;
  logic [XY_W-1:0]   cur_x     = '0;
  logic [XY_W-1:0]   cur_y     = '0;
  logic [HEAD_W-1:0] cur_hdg   = '0;
  logic              pos_valid = 1'b0;
  logic [AGE_W-1:0]  age_cnt   = '0;

  pos_status_t status_q [$];

  // Little-endian word out of the frame buffer
  function automatic logic [31:0] le_word(int unsigned ofs);
    return {shadow_frame[ofs+3], shadow_frame[ofs+2], shadow_frame[ofs+1], shadow_frame[ofs]};
  endfunction

  // Finite and within the magnitude bound (inclusive)
  function automatic logic float_ok(logic [31:0] bits, logic [30:0] lim);
    if (bits[30:23] == 8'hFF) return 1'b0;
    return bits[30:0] <= lim;
  endfunction

  // round(v * mult * 2^(off+150) / div), ties away from zero
  function automatic int to_q16(logic [31:0] bits, longint unsigned mult, int off,
                                longint unsigned div);
    longint unsigned mant, num, den, q;
    int sh;
    mant = longint'(bits[22:0]);
    if (bits[30:23] == 8'h00) begin
      sh = 1 + off;
    end else begin
      mant = mant | 64'h80_0000;
      sh = int'(bits[30:23]) + off;
    end
    if (sh >= 0) begin
      if (sh > 7) sh = 7;
      num = (mant * mult) << sh;
      den = div;
    end else begin
      if (-sh > 53) return 0;
      num = mant * mult;
      den = div << (-sh);
    end
    q = (2 * num + den) / (2 * den);
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return bits[31] ? -int'(q) : int'(q);
  endfunction

  // Advance the deframer state by one input transfer
  function automatic pos_status_t deframe_step(op_e op, logic [7:0] b);
    pos_status_t s;
    logic [31:0] a_bits, x_bits, y_bits;
    s = '0;
    if (op == OP_TICK) begin
      if (age_cnt != AGE_MAX) age_cnt = age_cnt + 1'b1;
    end else if (!in_sync) begin
      if (b == cfg_hdr1) begin
        shadow_frame[0] = b;
        fill_idx = 1;
        in_sync = 1'b1;
      end
    end else if (fill_idx == 1 && b != cfg_hdr2) begin
      // bad second byte may itself open a new header
      in_sync = 1'b0;
      fill_idx = 0;
      if (b == cfg_hdr1) begin
        shadow_frame[0] = b;
        fill_idx = 1;
        in_sync = 1'b1;
      end
    end else begin
      shadow_frame[fill_idx] = b;
      fill_idx++;
      if (fill_idx >= FRAME_LENGTH) begin
        s.complete = 1'b1;
        fill_idx = 0;
        in_sync = 1'b0;
        a_bits = le_word(OFS_HEADING);
        x_bits = le_word(OFS_X);
        y_bits = le_word(OFS_Y);
        if (shadow_frame[0] == cfg_hdr1 && shadow_frame[1] == cfg_hdr2 &&
            shadow_frame[OFS_TAIL0] == cfg_tail1 && shadow_frame[OFS_TAIL1] == cfg_tail2 &&
            float_ok(x_bits, LIM_XY_BITS) && float_ok(y_bits, LIM_XY_BITS) &&
            float_ok(a_bits, LIM_ANG_BITS)) begin
          cur_x = XY_W'(to_q16(x_bits, 1, -134, 1000));
          cur_y = XY_W'(to_q16(y_bits, 1, -134, 1000));
          cur_hdg = HEAD_W'(to_q16(a_bits, longint'(PI_Q29), -163, 180));
          pos_valid = 1'b1;
          age_cnt = '0;
          s.accepted = 1'b1;
        end
      end
    end
    s.x = cur_x;
    s.y = cur_y;
    s.hdg = cur_hdg;
    s.fresh = pos_valid && (age_cnt < cfg_stale);
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 40)
      $display("mismatch %0s: got %0h want %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // One item on the input stream, with random idle cycles ahead of it
  task automatic send_item(op_e op, logic [7:0] b);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    status_q.push_back(deframe_step(op, b));
    items_sent++;
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_item(OP_TICK, 8'($urandom));
  endtask

  // Full 28-byte frame built from the current register values
  task automatic send_frame(logic [31:0] a_bits, logic [31:0] x_bits, logic [31:0] y_bits,
                            frame_flaw_e flaw);
    logic [7:0] fr [FRAME_LENGTH];
    foreach (fr[i]) fr[i] = 8'($urandom);
    fr[0] = cfg_hdr1;
    fr[1] = cfg_hdr2;
    for (int k = 0; k < 4; k++) begin
      fr[OFS_HEADING+k] = a_bits[8*k +: 8];
      fr[OFS_X+k]       = x_bits[8*k +: 8];
      fr[OFS_Y+k]       = y_bits[8*k +: 8];
    end
    fr[OFS_TAIL0] = cfg_tail1;
    fr[OFS_TAIL1] = cfg_tail2;
    case (flaw)
      FLAW_TAIL_FIRST:    fr[OFS_TAIL0] = fr[OFS_TAIL0] ^ 8'($urandom_range(255, 1));
      FLAW_TAIL_SECOND:   fr[OFS_TAIL1] = fr[OFS_TAIL1] ^ 8'($urandom_range(255, 1));
      FLAW_HEADER_SECOND: fr[1] = fr[1] ^ 8'($urandom_range(255, 1));
      default: ;
    endcase
    foreach (fr[i]) begin
      if ($urandom_range(99) < tick_mix_pct) send_item(OP_TICK, 8'($urandom));
      send_item(OP_BYTE, fr[i]);
    end
  endtask

  // Random single, weighted toward in-range values, with bounds, NaN/inf and subnormals
  function automatic logic [31:0] rand_float(logic [30:0] lim, int unsigned emax);
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(15))
      0: ;
      1: f[30:0] = lim + 31'($urandom_range(2)) - 31'd1;
      2: f[30:23] = 8'h00;
      3: f[30:23] = 8'hFF;
      default: f[30:23] = 8'($urandom_range(emax, 100));
    endcase
    return f;
  endfunction

  // Stop offering and wait for every pending result
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (r)
      REG_HEADER_FIRST:  cfg_hdr1  = v[7:0];
      REG_HEADER_SECOND: cfg_hdr2  = v[7:0];
      REG_TAIL_FIRST:    cfg_tail1 = v[7:0];
      REG_TAIL_SECOND:   cfg_tail2 = v[7:0];
      REG_STALE_LIMIT:   cfg_stale = v;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(logic [7:0] h1, logic [7:0] h2, logic [7:0] t1, logic [7:0] t2,
                           logic [CFG_W-1:0] stale);
    drain();
    write_reg(REG_HEADER_FIRST, CFG_W'(h1));
    write_reg(REG_HEADER_SECOND, CFG_W'(h2));
    write_reg(REG_TAIL_FIRST, CFG_W'(t1));
    write_reg(REG_TAIL_SECOND, CFG_W'(t2));
    write_reg(REG_STALE_LIMIT, stale);
  endtask

  // Result check against the oldest prediction
  task automatic check_result(logic [71:0] d);
    pos_status_t w;
    if (status_q.size() == 0) begin
      report_mismatch("result with nothing pending", 32'(d[31:0]), 32'd0);
      return;
    end
    w = status_q.pop_front();
    if (d[0] !== w.complete) report_mismatch("frame_complete", 32'(d[0]), 32'(w.complete));
    if (d[1] !== w.accepted) report_mismatch("frame_accepted", 32'(d[1]), 32'(w.accepted));
    if (d[2 +: XY_W] !== w.x) report_mismatch("pos_x", 32'(d[2 +: XY_W]), 32'(w.x));
    if (d[24 +: XY_W] !== w.y) report_mismatch("pos_y", 32'(d[24 +: XY_W]), 32'(w.y));
    if (d[46 +: HEAD_W] !== w.hdg)
      report_mismatch("heading", 32'(d[46 +: HEAD_W]), 32'(w.hdg));
    if (d[66] !== w.fresh) report_mismatch("position_fresh", 32'(d[66]), 32'(w.fresh));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
  end

  // Result sink: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Ticks with no position, noise bytes, and header resync
  task automatic test_noise_and_resync;
    send_item(OP_TICK, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, cfg_hdr1);
    send_item(OP_BYTE, 8'h00);
    // lone first header byte, then the frame's own first byte restarts the hunt
    send_item(OP_BYTE, cfg_hdr1);
    send_frame(32'h43B4_0000, 32'h469C_4000, 32'hC69C_4000, FLAW_NONE);
    send_ticks(2);
  endtask

  // Range bounds, NaN, infinity, subnormals, negative zero and tail defects
  task automatic test_frame_checks;
    send_frame(32'hC3B4_0000, 32'h8000_0000, 32'h0000_0001, FLAW_NONE);
    send_frame(32'h3F80_0000, 32'h7FC0_0000, 32'h3F80_0000, FLAW_NONE);
    send_frame(32'h3F80_0000, 32'h3F80_0000, 32'hFF80_0000, FLAW_NONE);
    send_frame(32'h43B4_0001, 32'h3F80_0000, 32'h3F80_0000, FLAW_NONE);
    send_frame(32'h3F80_0000, 32'h469C_4001, 32'h3F80_0000, FLAW_NONE);
    send_frame(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, FLAW_TAIL_FIRST);
    send_frame(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, FLAW_TAIL_SECOND);
    send_frame(32'h3F80_0000, 32'h3F00_0000, 32'h007F_FFFF, FLAW_NONE);
    send_frame(32'h7F80_0000, 32'hC69C_4000, 32'h469C_4000, FLAW_NONE);
  endtask

  // Header register rewritten while a frame is half collected
  task automatic test_header_change_midframe;
    send_item(OP_BYTE, cfg_hdr1);
    send_item(OP_BYTE, cfg_hdr2);
    repeat (8) send_item(OP_BYTE, 8'($urandom));
    drain();
    write_reg(REG_HEADER_FIRST, CFG_W'(8'h55));
    repeat (16) send_item(OP_BYTE, 8'($urandom));
    send_item(OP_BYTE, cfg_tail1);
    send_item(OP_BYTE, cfg_tail2);
    send_frame(32'h4334_0000, 32'h4479_8000, 32'hC479_8000, FLAW_NONE);
  endtask

  // Stale limit extremes and age saturation
  task automatic test_age_and_freshness;
    configure(8'd13, 8'd10, 8'd10, 8'd13, 10'd1000);
    send_frame(32'h4234_0000, 32'h4120_0000, 32'hC120_0000, FLAW_NONE);
    send_ticks(1030);
    configure(8'd13, 8'd10, 8'd10, 8'd13, 10'd1);
    send_ticks(1);
    send_frame(32'h4234_0000, 32'h4120_0000, 32'hC120_0000, FLAW_NONE);
    send_ticks(2);
    configure(8'd13, 8'd10, 8'd10, 8'd13, 10'd0);
    send_frame(32'h4234_0000, 32'h4120_0000, 32'hC120_0000, FLAW_NONE);
    send_ticks(1);
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure;
    configure(8'hC3, 8'h3C, 8'h5A, 8'hA5, 10'd20);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_req = 300;
    repeat (3)
      send_frame(rand_float(LIM_ANG_BITS, 134), rand_float(LIM_XY_BITS, 140),
                 rand_float(LIM_XY_BITS, 140), FLAW_NONE);
    drain();
  endtask

  // Mostly well-formed frames with random content, mixed with noise and ticks
  task automatic run_random(int unsigned n, int unsigned src_pct, int unsigned sink_pct);
    int unsigned start;
    frame_flaw_e flaw;
    start = items_sent;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    tick_mix_pct = 8;
    while (items_sent - start < n) begin
      case ($urandom_range(9))
        0: repeat ($urandom_range(4, 1)) send_item(OP_BYTE, 8'($urandom));
        1: send_ticks($urandom_range(3, 1));
        default: begin
          flaw = FLAW_NONE;
          if ($urandom_range(4) == 0) flaw = frame_flaw_e'($urandom_range(3, 1));
          send_frame(rand_float(LIM_ANG_BITS, 134), rand_float(LIM_XY_BITS, 140),
                     rand_float(LIM_XY_BITS, 140), flaw);
        end
      endcase
    end
    tick_mix_pct = 0;
  endtask

  task automatic test_random_traffic;
    configure(8'h00, 8'hFF, 8'hFF, 8'h00, 10'd1000);
    run_random(30, 0, 0);
    configure(8'hFF, 8'h00, 8'h00, 8'hFF, 10'd1);
    run_random(30, 79, 0);
    configure(8'hA5, 8'hA5, 8'h0D, 8'h0A, CFG_W'($urandom_range(40, 2)));
    run_random(30, 0, 79);
    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              CFG_W'($urandom_range(1000, 1)));
    run_random(30, 29, 29);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_noise_and_resync();
    test_frame_checks();
    test_header_change_midframe();
    test_age_and_freshness();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
src/pfd_pkg.sv
src/position_frame_deframer.sv
tb/sv/position_frame_deframer_tb.sv
